// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is asserted.
`define PHC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Clocked invariant, disabled while reset is asserted.
`define PHC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ===== hdl/phc_pkg.sv =====
// Shared types, constants and the CRC-32 byte step for the header CRC checker.
// No dependencies.
package phc_pkg;

	localparam logic [15:0] MAX_PAYLOAD   = 16'd512;
	localparam logic [7:0]  TR_CLEAR_MASK = 8'b1101_1111;
	localparam logic [15:0] HEADER_BYTES  = 16'd12;
	localparam logic [15:0] TRAILER_BYTES = 16'd4;
	localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_TYPE = 3'd1;
	localparam logic [2:0] ST_BAD_TR   = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_BAD_CRC  = 3'd4;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_payload;
		logic        frame_done;
		logic [2:0]  status;
		logic [1:0]  pkt_type;
		logic        trunc_flag;
		logic [4:0]  window_size;
		logic [7:0]  seq_number;
		logic [15:0] payload_length;
		logic [31:0] time_stamp;
		logic        has_payload_crc;
	} phc_result_t;

	// Reflected CRC-32 (zlib), one byte, unrolled over eight bit steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hdl/phc_frame_parser.sv =====
// Frame state and per-byte result logic of the header CRC checker.
// Depends on phc_pkg.
module phc_frame_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output phc_pkg::phc_result_t result
);
	import phc_pkg::*;

	logic [15:0] cnt_q;
	logic [7:0]  hb0_q;
	logic [7:0]  seq_q;
	logic [15:0] len_q;
	logic [31:0] stamp_q;
	logic [31:0] crc_q;
	logic [31:0] rcrc_q;
	logic [31:0] tail_q;
	logic        hbad_q;

	logic [7:0]  hb0_n;
	logic [7:0]  seq_n;
	logic [15:0] len_n;
	logic [31:0] stamp_n;
	logic [31:0] crc_n;
	logic [31:0] rcrc_n;
	logic [31:0] tail_n;
	logic        hbad_n;
	logic        payload;
	logic [16:0] total;
	logic [16:0] len_ext;
	logic        has_crc;
	logic [2:0]  status;

	always_comb begin
		hb0_n   = hb0_q;
		seq_n   = seq_q;
		len_n   = len_q;
		stamp_n = stamp_q;
		crc_n   = crc_q;
		rcrc_n  = rcrc_q;
		tail_n  = tail_q;
		hbad_n  = hbad_q;
		payload = 1'b0;
		if (cnt_q == 16'd0) begin
			hb0_n = in_byte;
			crc_n = crc_byte(crc_q, in_byte & TR_CLEAR_MASK);
		end else if (cnt_q < 16'd8) begin
			if (cnt_q == 16'd1) begin
				seq_n = in_byte;
			end else if (cnt_q == 16'd2) begin
				len_n = {in_byte, 8'd0};
			end else if (cnt_q == 16'd3) begin
				len_n = {len_q[15:8], len_q[7:0] | in_byte};
			end else begin
				// bytes 4-7 land little-endian
				unique case (cnt_q[1:0])
					2'd0: stamp_n = stamp_q | {24'd0, in_byte};
					2'd1: stamp_n = stamp_q | {16'd0, in_byte, 8'd0};
					2'd2: stamp_n = stamp_q | {8'd0, in_byte, 16'd0};
					default: stamp_n = stamp_q | {in_byte, 24'd0};
				endcase
			end
			crc_n = crc_byte(crc_q, in_byte);
		end else if (cnt_q < HEADER_BYTES) begin
			rcrc_n = {rcrc_q[23:0], in_byte};
			if (cnt_q == HEADER_BYTES - 16'd1) begin
				hbad_n = (rcrc_n != ~crc_q);
				crc_n  = CRC_INIT;
			end
		end else if ((cnt_q - HEADER_BYTES) < len_q) begin
			payload = 1'b1;
			crc_n   = crc_byte(crc_q, in_byte);
		end else begin
			tail_n = {tail_q[23:0], in_byte};
		end
	end

	// Final-byte verdict, checks in priority order.
	always_comb begin
		total   = {1'b0, cnt_q} + 17'd1;
		len_ext = {1'b0, len_n};
		has_crc = 1'b0;
		status  = ST_OK;
		if (in_last) begin
			priority if (hb0_n[7:6] == 2'd0) begin
				status = ST_BAD_TYPE;
			end else if (hb0_n[5] && (len_n != 16'd0)) begin
				status = ST_BAD_TR;
			end else if ((cnt_q == COUNT_MAX) || (len_n > MAX_PAYLOAD)
					|| (total < {1'b0, HEADER_BYTES})
					|| ((total != len_ext + {1'b0, HEADER_BYTES})
					&& (total != len_ext + {1'b0, HEADER_BYTES + TRAILER_BYTES}))) begin
				status = ST_BAD_LEN;
			end else begin
				has_crc = (total == len_ext + {1'b0, HEADER_BYTES + TRAILER_BYTES});
				if (hbad_n || (has_crc && (tail_n != ~crc_n))) begin
					status = ST_BAD_CRC;
				end
			end
		end
	end

	always_comb begin
		result.out_byte        = in_byte;
		result.is_payload      = payload;
		result.frame_done      = in_last;
		result.status          = status;
		result.pkt_type        = hb0_n[7:6];
		result.trunc_flag      = hb0_n[5];
		result.window_size     = hb0_n[4:0];
		result.seq_number      = seq_n;
		result.payload_length  = len_n;
		result.time_stamp      = stamp_n;
		result.has_payload_crc = has_crc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 16'd0;
			hb0_q   <= 8'd0;
			seq_q   <= 8'd0;
			len_q   <= 16'd0;
			stamp_q <= 32'd0;
			crc_q   <= CRC_INIT;
			rcrc_q  <= 32'd0;
			tail_q  <= 32'd0;
			hbad_q  <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				cnt_q   <= 16'd0;
				hb0_q   <= 8'd0;
				seq_q   <= 8'd0;
				len_q   <= 16'd0;
				stamp_q <= 32'd0;
				crc_q   <= CRC_INIT;
				rcrc_q  <= 32'd0;
				tail_q  <= 32'd0;
				hbad_q  <= 1'b0;
			end else begin
				cnt_q   <= (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
				hb0_q   <= hb0_n;
				seq_q   <= seq_n;
				len_q   <= len_n;
				stamp_q <= stamp_n;
				crc_q   <= crc_n;
				rcrc_q  <= rcrc_n;
				tail_q  <= tail_n;
				hbad_q  <= hbad_n;
			end
		end
	end

endmodule

// ===== hdl/packet_header_crc_checker_core.sv =====
// Top level of the packet header CRC checker: stream ports and result register.
// Depends on phc_pkg, phc_frame_parser and assert_macros.svh.
//
// Deframes packets arriving one byte per beat (tlast on the final byte) and
// returns one result beat per input beat through the result register. Header: byte 0 is
// type[7:6] (1 data, 2 ack, 3 nack), tr[5], window[4:0]; byte 1 seqnum;
// bytes 2-3 big-endian length; bytes 4-7 timestamp (byte 4 lowest); bytes
// 8-11 big-endian CRC-32 (zlib) of bytes 0-7 with tr cleared. Payload follows,
// optionally trailed by its big-endian CRC-32. Each result echoes the byte,
// flags payload bytes on tuser, and carries the header fields captured so
// far. On the tlast beat status is set (0 ok, 1 bad type, 2 bad tr with
// nonzero length, 3 bad length, 4 CRC mismatch), checked in that order; it is
// 0 on all other beats. Throughput is one beat per clock with no gaps while the
// sink is ready; the path that sets the clock is the byte-wide unrolled CRC-32
// step plus the 32-bit compare feeding the result register. The result register
// lets a new beat in whenever it is empty or being drained in the same cycle.
module packet_header_crc_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] out_byte, [10:8] status, [12:11] pkt_type, [13] trunc_flag,
	// [18:14] window_size, [26:19] seq_number, [42:27] payload_length,
	// [74:43] time_stamp, [75] has_payload_crc, [79:76] zero
	output logic [79:0] m_axis_tdata,
	output logic        m_axis_tlast,   // frame_done
	output logic        m_axis_tuser    // is_payload
);
	import phc_pkg::*;

	`include "assert_macros.svh"

	logic        take;
	phc_result_t res_next;
	phc_result_t res_q;
	logic        valid_q;

	assign s_axis_tready = !valid_q || m_axis_tready;
	assign take          = s_axis_tvalid && s_axis_tready;

	phc_frame_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (s_axis_tdata),
		.in_last (s_axis_tlast),
		.result  (res_next)
	);

	// result register: control reset, payload unreset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = res_q.frame_done;
	assign m_axis_tuser  = res_q.is_payload;
	assign m_axis_tdata  = {4'd0, res_q.has_payload_crc, res_q.time_stamp,
		res_q.payload_length, res_q.seq_number, res_q.window_size,
		res_q.trunc_flag, res_q.pkt_type, res_q.status, res_q.out_byte};

	// status is only meaningful on the final beat
	`PHC_ASSERT_IMPL(a_status_only_on_done, m_axis_tvalid && !m_axis_tlast,
		m_axis_tdata[10:8] == ST_OK, "status set on a non-final beat")

	// trailing CRC flag only on a final, non-payload beat
	`PHC_ASSERT_IMPL(a_crc_flag_on_tail, m_axis_tvalid && m_axis_tdata[75],
		m_axis_tlast && !m_axis_tuser, "payload CRC flag on wrong beat")

	// type zero on the final beat is exactly the bad-type verdict
	`PHC_ASSERT_ALWAYS(a_bad_type_match, !(m_axis_tvalid && m_axis_tlast)
		|| ((m_axis_tdata[12:11] == 2'd0) == (m_axis_tdata[10:8] == ST_BAD_TYPE)),
		"bad type verdict does not match type field")

	// an accepted beat always shows up in the result register
	`PHC_ASSERT_IMPL(a_take_fills, $past(take && arst_n), m_axis_tvalid,
		"accepted beat lost")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for packet_header_crc_checker_core: byte frames in, one result per byte.
// Depends on phc_pkg (types, status codes, header constants) and the core RTL.
// A scoreboard class predicts every result beat and checks it. Plain tasks build and drive the frames.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import phc_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no beat on either side
	localparam int unsigned DRAIN_CYCLES = 10;    // extra wait after every expected result has arrived
	localparam int unsigned PHASE_BEATS  = 40;

	typedef enum {MUT_NONE, MUT_HDR_CRC, MUT_PAY_CRC, MUT_CUT, MUT_PAD} frame_fault_t;

	// Tracks deframer state per accepted byte and queues the result it must produce.
	class frame_scoreboard_t;
		phc_result_t expected_q[$];
		int unsigned n_errors;
		int unsigned n_frames;
		int unsigned outcome_count[5];
		logic [15:0] byte_idx;
		logic [7:0]  hdr0;
		logic [7:0]  seq;
		logic [15:0] len;
		logic [31:0] stamp;
		logic [31:0] crc_run;
		logic [31:0] hdr_crc_rx;
		logic [31:0] tail;
		logic        hdr_crc_bad;

		function new();
			n_errors = 0;
			n_frames = 0;
			foreach (outcome_count[i]) outcome_count[i] = 0;
			clear_state();
		endfunction

		function void clear_state();
			byte_idx = '0;
			hdr0 = '0;
			seq = '0;
			len = '0;
			stamp = '0;
			crc_run = CRC_INIT;
			hdr_crc_rx = '0;
			tail = '0;
			hdr_crc_bad = 1'b0;
		endfunction

		// Reflected CRC-32, fed LSB first one bit at a time.
		static function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			logic        fb;
			r = c;
			for (int i = 0; i < 8; i++) begin
				fb = r[0] ^ b[i];
				r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'h0);
			end
			return r;
		endfunction

		function void note_beat(logic [7:0] b, logic last);
			phc_result_t want;
			int unsigned idx;
			int unsigned total;
			int unsigned dlen;
			want = '0;
			idx = 32'(byte_idx);
			if (idx == 0) begin
				hdr0 = b;
				crc_run = crc32_step(crc_run, b & TR_CLEAR_MASK);
			end else if (idx < 8) begin
				case (idx)
					1: seq = b;
					2: len = {b, 8'h00};
					3: len = len | {8'h00, b};
					default: stamp = stamp | ({24'h0, b} << (8 * (idx - 4)));
				endcase
				crc_run = crc32_step(crc_run, b);
			end else if (idx < HEADER_BYTES) begin
				// header CRC arrives big-endian
				hdr_crc_rx = {hdr_crc_rx[23:0], b};
				if (idx == HEADER_BYTES - 1) begin
					hdr_crc_bad = (hdr_crc_rx != ~crc_run);
					crc_run = CRC_INIT;
				end
			end else if (idx - HEADER_BYTES < {16'h0, len}) begin
				want.is_payload = 1'b1;
				crc_run = crc32_step(crc_run, b);
			end else begin
				tail = {tail[23:0], b};
			end
			if (byte_idx != COUNT_MAX) byte_idx = byte_idx + 16'd1;

			want.out_byte = b;
			want.frame_done = last;
			want.status = ST_OK;
			if (last) begin
				total = idx + 1;
				dlen = 32'(len);
				if (hdr0[7:6] == 2'b00) begin
					want.status = ST_BAD_TYPE;
				end else if (hdr0[5] && dlen != 0) begin
					want.status = ST_BAD_TR;
				end else if (idx == COUNT_MAX || dlen > MAX_PAYLOAD || total < HEADER_BYTES ||
						(total != dlen + HEADER_BYTES &&
						total != dlen + HEADER_BYTES + TRAILER_BYTES)) begin
					want.status = ST_BAD_LEN;
				end else begin
					want.has_payload_crc = (total == dlen + HEADER_BYTES + TRAILER_BYTES);
					if (hdr_crc_bad || (want.has_payload_crc && tail != ~crc_run))
						want.status = ST_BAD_CRC;
				end
			end
			want.pkt_type = hdr0[7:6];
			want.trunc_flag = hdr0[5];
			want.window_size = hdr0[4:0];
			want.seq_number = seq;
			want.payload_length = len;
			want.time_stamp = stamp;
			expected_q.push_back(want);
			if (last) clear_state();
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				n_errors++;
			end
		endfunction

		function void check_result(logic [79:0] data, logic last, logic user);
			phc_result_t want;
			if (expected_q.size() == 0) begin
				$error("result beat 0x%0h with no pending expectation", data);
				n_errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("out_byte", 32'(want.out_byte), 32'(data[7:0]));
			compare_field("is_payload", 32'(want.is_payload), 32'(user));
			compare_field("frame_done", 32'(want.frame_done), 32'(last));
			compare_field("status", 32'(want.status), 32'(data[10:8]));
			compare_field("pkt_type", 32'(want.pkt_type), 32'(data[12:11]));
			compare_field("trunc_flag", 32'(want.trunc_flag), 32'(data[13]));
			compare_field("window_size", 32'(want.window_size), 32'(data[18:14]));
			compare_field("seq_number", 32'(want.seq_number), 32'(data[26:19]));
			compare_field("payload_length", 32'(want.payload_length), 32'(data[42:27]));
			compare_field("time_stamp", want.time_stamp, data[74:43]);
			compare_field("has_payload_crc", 32'(want.has_payload_crc), 32'(data[75]));
			compare_field("tdata pad", 32'h0, 32'(data[79:76]));
			if (want.frame_done) begin
				n_frames++;
				if (want.status <= ST_BAD_CRC) outcome_count[want.status]++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic        s_axis_tlast = 1'b0;    // in_last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;           // result fields, out_byte in [7:0]
	logic        m_axis_tlast;           // frame_done
	logic        m_axis_tuser;           // is_payload

	frame_scoreboard_t sb;
	logic [7:0]  frame_bytes[$];
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned beats_sent = 0;
	int unsigned quiet_cycles = 0;

	packet_header_crc_checker_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Sink side: random stalls at the phase rate.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Check the result beat first: it always belongs to a byte taken at an earlier edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_beat(s_axis_tdata, s_axis_tlast);
		end
	end

	// Watchdog: a hung handshake on both sides ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("no beat for %0d cycles", QUIET_LIMIT);
			$display("packet_header_crc_checker_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Header with the CRC over bytes 0-7 (tr cleared), payload, optional payload CRC,
	// then an optional damage step.
	function automatic void build_frame(logic [1:0] ptype, logic tr, logic [4:0] win,
			logic [7:0] seq, logic [15:0] dlen, logic [31:0] stamp, int unsigned n_pay,
			logic trailer, frame_fault_t fault);
		logic [31:0] crc;
		logic [7:0]  b;
		int unsigned pos;
		frame_bytes.delete();
		frame_bytes.push_back({ptype, tr, win});
		frame_bytes.push_back(seq);
		frame_bytes.push_back(dlen[15:8]);
		frame_bytes.push_back(dlen[7:0]);
		for (int i = 0; i < 4; i++) frame_bytes.push_back(stamp[8*i +: 8]);
		crc = CRC_INIT;
		for (int i = 0; i < 8; i++)
			crc = frame_scoreboard_t::crc32_step(crc,
				(i == 0) ? (frame_bytes[0] & TR_CLEAR_MASK) : frame_bytes[i]);
		crc = ~crc;
		for (int i = 3; i >= 0; i--) frame_bytes.push_back(crc[8*i +: 8]);
		crc = CRC_INIT;
		for (int unsigned i = 0; i < n_pay; i++) begin
			b = 8'($urandom);
			frame_bytes.push_back(b);
			crc = frame_scoreboard_t::crc32_step(crc, b);
		end
		crc = ~crc;
		if (trailer)
			for (int i = 3; i >= 0; i--) frame_bytes.push_back(crc[8*i +: 8]);
		case (fault)
			MUT_HDR_CRC: begin
				pos = $urandom_range(11, 8);
				frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
			end
			MUT_PAY_CRC: begin
				pos = frame_bytes.size() - 1 - $urandom_range(3);
				frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
			end
			MUT_CUT: repeat ($urandom_range(frame_bytes.size() - 1, 1))
				void'(frame_bytes.pop_back());
			MUT_PAD: repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom));
			default: ;
		endcase
	endfunction

	task automatic send_beat(logic [7:0] b, logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// Random frames under one flow-control setting; mostly well-formed with random content.
	task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n_beats);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		logic [1:0]  t;
		logic        trailer;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(99);
			t = 2'($urandom_range(3, 1));
			n = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 0);
			trailer = 1'($urandom_range(1));
			if (pick < 62)
				build_frame(t, (n == 0) ? 1'($urandom_range(1)) : 1'b0, 5'($urandom),
					8'($urandom), 16'(n), $urandom, n, trailer, MUT_NONE);
			else if (pick < 70)
				build_frame(t, 1'b0, 5'($urandom), 8'($urandom), 16'(n), $urandom, n,
					trailer, MUT_HDR_CRC);
			else if (pick < 76)
				build_frame(t, 1'b0, 5'($urandom), 8'($urandom), 16'(n), $urandom, n,
					1'b1, MUT_PAY_CRC);
			else if (pick < 81)
				build_frame(t, 1'b0, 5'($urandom), 8'($urandom), 16'(n), $urandom, n,
					trailer, MUT_CUT);
			else if (pick < 86)
				build_frame(t, 1'b0, 5'($urandom), 8'($urandom), 16'(n), $urandom, n,
					trailer, MUT_PAD);
			else if (pick < 89)
				build_frame(2'b00, 1'($urandom_range(1)), 5'($urandom), 8'($urandom),
					16'(n), $urandom, n, trailer, MUT_NONE);
			else if (pick < 92)
				build_frame(t, 1'b1, 5'($urandom), 8'($urandom), 16'(n + 1), $urandom,
					n + 1, trailer, MUT_NONE);
			else if (pick < 95)
				build_frame(t, 1'b0, 5'($urandom), 8'($urandom),
					16'($urandom_range(65535, 513)), $urandom, $urandom_range(8, 0),
					trailer, MUT_NONE);
			else begin
				frame_bytes.delete();
				repeat ($urandom_range(40, 1)) frame_bytes.push_back(8'($urandom));
			end
			send_frame();
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames, no flow-control gaps.
		build_frame(2'd1, 1'b0, 5'd3, 8'h00, 16'd4, 32'h0, 4, 1'b1, MUT_NONE);
		send_frame();
		// tr with zero length is legal; the trailer is then the CRC of nothing
		build_frame(2'd2, 1'b1, 5'd0, 8'h01, 16'd0, $urandom, 0, 1'b1, MUT_NONE);
		send_frame();
		build_frame(2'd2, 1'b0, 5'd7, 8'h02, 16'd0, $urandom, 0, 1'b0, MUT_NONE);
		send_frame();
		build_frame(2'd0, 1'b0, 5'd1, 8'h03, 16'd2, $urandom, 2, 1'b0, MUT_NONE);
		send_frame();
		build_frame(2'd3, 1'b1, 5'd2, 8'h04, 16'd3, $urandom, 3, 1'b1, MUT_NONE);
		send_frame();
		build_frame(2'd1, 1'b0, 5'd4, 8'h05, 16'd1, $urandom, 1, 1'b0, MUT_HDR_CRC);
		send_frame();
		build_frame(2'd3, 1'b0, 5'd5, 8'h06, 16'd2, $urandom, 2, 1'b1, MUT_PAY_CRC);
		send_frame();
		// declared length just over the limit
		build_frame(2'd1, 1'b0, 5'd6, 8'h07, 16'd513, $urandom, 0, 1'b0, MUT_NONE);
		send_frame();
		// one-byte frame, then a frame one byte short of a header
		frame_bytes.delete();
		frame_bytes.push_back(8'h45);
		send_frame();
		build_frame(2'd2, 1'b0, 5'd8, 8'h08, 16'd0, $urandom, 0, 1'b0, MUT_NONE);
		void'(frame_bytes.pop_back());
		send_frame();
		// field extremes with the largest legal payload
		build_frame(2'd3, 1'b0, 5'd31, 8'hFF, MAX_PAYLOAD, 32'hFFFF_FFFF, MAX_PAYLOAD,
			1'b1, MUT_NONE);
		send_frame();

		run_phase(0, 0, PHASE_BEATS);
		run_phase(77, 0, PHASE_BEATS);
		run_phase(0, 77, PHASE_BEATS);
		run_phase(15, 15, PHASE_BEATS);
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			$error("%0d result beats never arrived", sb.expected_q.size());
			sb.n_errors++;
		end

		$display("run: %0d bytes in %0d frames across four flow-control phases",
			beats_sent, sb.n_frames);
		$display("frame outcomes: ok %0d, bad type %0d, bad tr %0d, bad length %0d, crc %0d",
			sb.outcome_count[0], sb.outcome_count[1], sb.outcome_count[2],
			sb.outcome_count[3], sb.outcome_count[4]);
		if (sb.n_errors == 0) begin
			$display("packet_header_crc_checker_core verification clean");
		end else begin
			$display("packet_header_crc_checker_core verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/phc_pkg.sv
hdl/phc_frame_parser.sv
hdl/packet_header_crc_checker_core.sv
tb/testbench.sv
